>>> hdl/graph_traversal_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Graph traversal engine assertion macros
// Shared macros for the concurrent checks of the graph traversal engine.
// ----------------------------------------------------------------------------
`ifndef GRAPH_TRAVERSAL_ENGINE_TOP_DEFINES_SVH
`define GRAPH_TRAVERSAL_ENGINE_TOP_DEFINES_SVH

// An implication that is checked on every rising clock edge out of reset.
`define GTE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A signal that must hold its value while a condition is true.
`define GTE_ASSERT_HOLD(label, clk, rstn, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) cond |=> $stable(sig)) \
    else $error(msg);

`endif

>>> hdl/gte_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal engine package
// Operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package gte_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_BFS  = 2'd1,
    FUNC_DFS  = 2'd2,
    FUNC_COMP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_EMIT,
    S_SCAN,
    S_SCAN_RD,
    S_Q_POP,
    S_Q_RD,
    S_B_LIST,
    S_B_EDGE,
    S_B_TEST,
    S_D_TOP,
    S_D_EDGE,
    S_D_TEST,
    S_ADD_LINK,
    S_FLUSH
  } state_e;

endpackage

>>> hdl/gte_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read per cycle with an optional write; the read data are registered.
// ----------------------------------------------------------------------------
module gte_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/graph_traversal_engine_top.sv
// ----------------------------------------------------------------------------
// Graph traversal engine
// A directed graph kept as per-vertex edge lists, walked breadth-first,
// depth-first or by connected components under one small sequencer.
// ----------------------------------------------------------------------------
// One item is handled at a time, and the input stalls until any last result
// beat has been taken. An add-edge passes through the link state, and also
// through the flush state when the source list already holds edges. A
// traversal first clears the visited map. Breadth-first, each vertex is
// popped, read, emitted and has its list fetched, and each edge is tested and
// the next one fetched; depth-first, each vertex is emitted and pushed, and
// each edge is tested from the stack; components mode scans for the next
// unvisited vertex. All accesses go through the single port of each edge,
// list and work memory. A result beat is held back until the next vertex is
// found or the walk ends, so that its last flag is known when it is offered;
// the final beat is offered back in the idle state once that flag is set. A
// full store holds MaxVertices vertices and MaxEdges edges.
`include "graph_traversal_engine_top_defines.svh"

module graph_traversal_engine_top #(
  parameter int MaxVertices = 64,
  parameter int MaxEdges    = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [5:0] first_vertex_i,
  input  logic [5:0] second_vertex_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] vertex_o,
  output logic [5:0] component_o,
  output logic [1:0] status_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int CW = EW + 1;

  gte_pkg::state_e state_q, state_d, ret_q, ret_d;

  logic [6:0]  vcount_q;
  logic [6:0]  n_w;
  logic [CW-1:0] used_q, used_d;

  logic [1:0]  func_q, func_d;
  logic [5:0]  a_q, a_d, b_q, b_d;

  logic [MaxVertices-1:0] lvalid_q, lvalid_d;
  logic [MaxVertices-1:0] vis_q, vis_d;

  logic [VW:0] qh_q, qh_d, qt_q, qt_d;
  logic [VW:0] sp_q, sp_d;
  logic [VW:0] i_q, i_d;
  logic [5:0]  comp_q, comp_d;
  logic [5:0]  x_q, x_d;
  logic [EW-1:0] e_q, e_d;
  logic [EW-1:0] tail_q, tail_d;
  logic        stop_q, stop_d;
  logic        any_q, any_d;

  logic        ov_q, ov_d;
  logic [5:0]  ovx_q, ovx_d, ovc_q, ovc_d;
  logic [1:0]  ovs_q, ovs_d;
  logic        ovl_q, ovl_d;
  logic        last_pend_q, last_pend_d;

  logic          hd_we, tl_we, tg_we, nx_we, q_we, st_we;
  logic [VW-1:0] hd_a, tl_a, q_a, st_a;
  logic [EW-1:0] tg_a, nx_a;
  logic [EW-1:0] hd_wd, tl_wd, nx_wd, hd_rd, tl_rd, nx_rd;
  logic [5:0]    tg_wd, tg_rd, q_wd, q_rd;
  logic [VW+EW:0] st_wd, st_rd;

  gte_ram #(.Width(EW), .Depth(MaxVertices)) u_head (
    .clk_i, .we_i(hd_we), .addr_i(hd_a), .wdata_i(hd_wd), .rdata_o(hd_rd));
  gte_ram #(.Width(EW), .Depth(MaxVertices)) u_tail (
    .clk_i, .we_i(tl_we), .addr_i(tl_a), .wdata_i(tl_wd), .rdata_o(tl_rd));
  gte_ram #(.Width(6), .Depth(MaxEdges)) u_target (
    .clk_i, .we_i(tg_we), .addr_i(tg_a), .wdata_i(tg_wd), .rdata_o(tg_rd));
  gte_ram #(.Width(EW), .Depth(MaxEdges)) u_next (
    .clk_i, .we_i(nx_we), .addr_i(nx_a), .wdata_i(nx_wd), .rdata_o(nx_rd));
  gte_ram #(.Width(6), .Depth(MaxVertices)) u_queue (
    .clk_i, .we_i(q_we), .addr_i(q_a), .wdata_i(q_wd), .rdata_o(q_rd));
  gte_ram #(.Width(VW + EW + 1), .Depth(MaxVertices)) u_stack (
    .clk_i, .we_i(st_we), .addr_i(st_a), .wdata_i(st_wd), .rdata_o(st_rd));

  assign n_w = (vcount_q > 7'(MaxVertices)) ? 7'(MaxVertices) : vcount_q;

  assign in_stall_o  = (state_q != gte_pkg::S_IDLE) || ov_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ov_q && ((state_q == gte_pkg::S_EMIT) ||
                                (state_q == gte_pkg::S_IDLE && !last_pend_q));
  assign vertex_o    = ovx_q;
  assign component_o = ovc_q;
  assign status_o    = ovs_q;
  assign last_o      = ovl_q;

  logic out_free;
  logic [5:0] t_w;
  logic [5:0] sx_w;
  logic [EW-1:0] se_w;
  logic sm_w;
  assign out_free = !ov_q || !out_stall_i;
  assign t_w  = tg_rd;
  assign sx_w = 6'(st_rd[VW+EW:EW+1]);
  assign se_w = st_rd[EW:1];
  assign sm_w = st_rd[0];

  always_comb begin
    state_d = state_q; ret_d = ret_q; used_d = used_q;
    func_d = func_q; a_d = a_q; b_d = b_q;
    lvalid_d = lvalid_q; vis_d = vis_q;
    qh_d = qh_q; qt_d = qt_q; sp_d = sp_q; i_d = i_q; comp_d = comp_q;
    x_d = x_q; e_d = e_q; tail_d = tail_q; stop_d = stop_q; any_d = any_q;
    ov_d = ov_q; ovx_d = ovx_q; ovc_d = ovc_q; ovs_d = ovs_q; ovl_d = ovl_q;
    last_pend_d = last_pend_q;
    hd_we = 1'b0; tl_we = 1'b0; tg_we = 1'b0; nx_we = 1'b0; q_we = 1'b0; st_we = 1'b0;
    hd_a = a_q[VW-1:0]; tl_a = a_q[VW-1:0]; q_a = qh_q[VW-1:0]; st_a = sp_q[VW-1:0];
    tg_a = e_q; nx_a = e_q;
    hd_wd = used_q[EW-1:0]; tl_wd = used_q[EW-1:0]; nx_wd = used_q[EW-1:0];
    tg_wd = b_q; q_wd = x_q; st_wd = '0;

    if (out_valid_o && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      gte_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          func_d = func_i; a_d = first_vertex_i; b_d = second_vertex_i;
          i_d = '0; comp_d = '0; any_d = 1'b0;
          if (func_i == gte_pkg::FUNC_ADD) begin
            if ({1'b0, first_vertex_i} >= n_w || {1'b0, second_vertex_i} >= n_w) begin
              ov_d = 1'b1; ovx_d = '0; ovc_d = '0; ovs_d = gte_pkg::STAT_RANGE; ovl_d = 1'b1;
            end else if (used_q >= CW'(MaxEdges)) begin
              ov_d = 1'b1; ovx_d = '0; ovc_d = '0; ovs_d = gte_pkg::STAT_FULL; ovl_d = 1'b1;
            end else begin
              tl_a = first_vertex_i[VW-1:0];
              state_d = gte_pkg::S_ADD_LINK;
            end
          end else if (func_i != gte_pkg::FUNC_COMP && {1'b0, first_vertex_i} >= n_w) begin
            ov_d = 1'b1; ovx_d = '0; ovc_d = '0; ovs_d = gte_pkg::STAT_RANGE; ovl_d = 1'b1;
          end else begin
            state_d = gte_pkg::S_CLEAR;
          end
        end
      end
      gte_pkg::S_ADD_LINK: begin
        tg_a = used_q[EW-1:0]; tg_we = 1'b1;
        if (lvalid_q[a_q[VW-1:0]]) begin
          tg_we = 1'b1;
        end
        hd_we = !lvalid_q[a_q[VW-1:0]];
        tl_we = 1'b1;
        lvalid_d[a_q[VW-1:0]] = 1'b1;
        used_d = used_q + CW'(1);
        state_d = lvalid_q[a_q[VW-1:0]] ? gte_pkg::S_FLUSH : gte_pkg::S_IDLE;
      end
      gte_pkg::S_FLUSH: begin
        nx_a = tl_rd; nx_we = 1'b1; nx_wd = used_q[EW-1:0] - EW'(1);
        state_d = gte_pkg::S_IDLE;
      end
      gte_pkg::S_CLEAR: begin
        vis_d = '0;
        if (func_q == gte_pkg::FUNC_COMP) begin
          state_d = gte_pkg::S_SCAN;
        end else begin
          x_d = a_q; vis_d[a_q[VW-1:0]] = 1'b1;
          if (func_q == gte_pkg::FUNC_BFS) begin
            q_a = '0; q_we = 1'b1; q_wd = a_q; qh_d = '0; qt_d = (VW+1)'(1);
            state_d = gte_pkg::S_Q_POP;
          end else begin
            state_d = gte_pkg::S_EMIT; ret_d = gte_pkg::S_D_TOP;
            sp_d = '0;
          end
        end
      end
      gte_pkg::S_SCAN: begin
        if (i_q >= (VW+1)'(n_w)) begin
          state_d = gte_pkg::S_IDLE;
          last_pend_d = any_q;
        end else if (vis_q[i_q[VW-1:0]]) begin
          i_d = i_q + 1'b1;
        end else begin
          vis_d[i_q[VW-1:0]] = 1'b1;
          q_a = '0; q_we = 1'b1; q_wd = 6'(i_q); qh_d = '0; qt_d = (VW+1)'(1);
          state_d = gte_pkg::S_Q_POP;
        end
      end
      gte_pkg::S_Q_POP: begin
        if (qh_q == qt_q) begin
          if (func_q == gte_pkg::FUNC_COMP) begin
            comp_d = comp_q + 1'b1; i_d = i_q + 1'b1;
            state_d = gte_pkg::S_SCAN;
          end else begin
            state_d = gte_pkg::S_IDLE; last_pend_d = 1'b1;
          end
        end else begin
          q_a = qh_q[VW-1:0];
          state_d = gte_pkg::S_Q_RD;
        end
      end
      gte_pkg::S_Q_RD: begin
        x_d = q_rd; qh_d = qh_q + 1'b1;
        hd_a = q_rd[VW-1:0]; tl_a = q_rd[VW-1:0];
        state_d = gte_pkg::S_EMIT; ret_d = gte_pkg::S_B_LIST;
      end
      gte_pkg::S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; ovx_d = x_q; ovs_d = gte_pkg::STAT_OK; ovl_d = 1'b0; any_d = 1'b1;
          ovc_d = (func_q == gte_pkg::FUNC_COMP) ? comp_q : 6'd0;
          hd_a = x_q[VW-1:0]; tl_a = x_q[VW-1:0];
          state_d = ret_q;
        end
      end
      gte_pkg::S_B_LIST: begin
        e_d = hd_rd; tail_d = tl_rd;
        tg_a = hd_rd; nx_a = hd_rd;
        state_d = lvalid_q[x_q[VW-1:0]] ? gte_pkg::S_B_TEST : gte_pkg::S_Q_POP;
      end
      gte_pkg::S_B_EDGE: begin
        tg_a = e_q; nx_a = e_q;
        state_d = gte_pkg::S_B_TEST;
      end
      gte_pkg::S_B_TEST: begin
        if ({1'b0, t_w} < n_w && !vis_q[t_w[VW-1:0]] && qt_q < (VW+1)'(MaxVertices)) begin
          vis_d[t_w[VW-1:0]] = 1'b1;
          q_a = qt_q[VW-1:0]; q_we = 1'b1; q_wd = t_w; qt_d = qt_q + 1'b1;
        end
        if (e_q == tail_q) begin
          state_d = gte_pkg::S_Q_POP;
        end else begin
          e_d = nx_rd; state_d = gte_pkg::S_B_EDGE;
        end
      end
      gte_pkg::S_D_TOP: begin
        st_a = sp_q[VW-1:0]; st_we = 1'b1;
        st_wd = {VW'(x_q), hd_rd, lvalid_q[x_q[VW-1:0]]};
        sp_d = sp_q + 1'b1;
        state_d = gte_pkg::S_D_EDGE; ret_d = gte_pkg::S_D_EDGE;
        stop_d = 1'b1;
      end
      gte_pkg::S_D_EDGE: begin
        if (stop_q) begin
          stop_d = 1'b0;
          if (sp_q == '0) begin
            state_d = gte_pkg::S_IDLE; last_pend_d = 1'b1;
          end else begin
            st_a = sp_q[VW-1:0] - VW'(1);
          end
        end else begin
          if (!sm_w) begin
            sp_d = sp_q - 1'b1; stop_d = 1'b1;
          end else begin
            x_d = sx_w; e_d = se_w;
            tl_a = sx_w[VW-1:0]; tg_a = se_w; nx_a = se_w;
            state_d = gte_pkg::S_D_TEST;
          end
        end
      end
      gte_pkg::S_D_TEST: begin
        st_a = sp_q[VW-1:0] - VW'(1); st_we = 1'b1;
        st_wd = {VW'(x_q), (e_q == tl_rd) ? e_q : nx_rd, e_q != tl_rd};
        stop_d = 1'b1; state_d = gte_pkg::S_D_EDGE;
        if ({1'b0, t_w} < n_w && !vis_q[t_w[VW-1:0]] && sp_q < (VW+1)'(MaxVertices)) begin
          vis_d[t_w[VW-1:0]] = 1'b1;
          x_d = t_w; ret_d = gte_pkg::S_D_TOP; state_d = gte_pkg::S_EMIT;
        end
      end
      default: state_d = gte_pkg::S_IDLE;
    endcase

    if (last_pend_q && ov_q && !ovl_q) begin
      ovl_d = 1'b1;
      last_pend_d = 1'b0;
    end else if (last_pend_q) begin
      last_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gte_pkg::S_IDLE;
      ret_q <= gte_pkg::S_IDLE;
      vcount_q <= 7'd64;
      used_q <= '0;
      lvalid_q <= '0;
      vis_q <= '0;
      ov_q <= 1'b0;
      last_pend_q <= 1'b0;
      stop_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
      used_q <= used_d;
      lvalid_q <= lvalid_d;
      vis_q <= vis_d;
      ov_q <= ov_d;
      last_pend_q <= last_pend_d;
      stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; a_q <= a_d; b_q <= b_d;
    qh_q <= qh_d; qt_q <= qt_d; sp_q <= sp_d; i_q <= i_d; comp_q <= comp_d;
    x_q <= x_d; e_q <= e_d; tail_q <= tail_d; any_q <= any_d;
    ovx_q <= ovx_d; ovc_q <= ovc_d; ovs_q <= ovs_d; ovl_q <= ovl_d;
  end

  `GTE_ASSERT(a_busy_stall, clk_i, rst_ni, (state_q != gte_pkg::S_IDLE) |-> in_stall_o, "busy without stall")
  `GTE_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, vertex_o, "payload moved")
  `GTE_ASSERT(a_used_max, clk_i, rst_ni, used_q <= CW'(MaxEdges), "edge count overflow")
  `GTE_ASSERT(a_err_last, clk_i, rst_ni, (out_valid_o && status_o != gte_pkg::STAT_OK) |-> last_o, "error not last")

endmodule
